// ----- rtl/mrtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrtc_pkg
// shared types, constants and the crc-16 byte update for the modbus rtu
// transmit crc append block
// ----------------------------------------------------------------------------
package mrtc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // output sequencer phases
  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PhData  = 2'd0;
  localparam logic [PhaseW-1:0] PhCrcLo = 2'd1;
  localparam logic [PhaseW-1:0] PhCrcHi = 2'd2;

  // one classified byte, as queued for the back end
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_last;
    logic [CrcW-1:0]  crc;        // crc including this byte
  } mrtc_entry_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } mrtc_fifo_status_t;

  // reflected crc-16, one byte, eight shift steps
  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrtc_front.sv -----
// ----------------------------------------------------------------------------
// mrtc_front
// accepts payload bytes, keeps the running crc and queues each byte with
// the crc that covers it
// ----------------------------------------------------------------------------
module mrtc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mrtc_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         frame_last_i,
  input  mrtc_pkg::mrtc_fifo_status_t  fifo_status_i,
  output logic                         push_o,
  output mrtc_pkg::mrtc_entry_t        push_entry_o
);

  logic [mrtc_pkg::CrcW-1:0] crc_q, crc_d;
  logic [mrtc_pkg::CrcW-1:0] crc_next;

  assign in_ready_o = ~fifo_status_i.full;
  assign push_o     = in_valid_i & in_ready_o;
  assign crc_next   = mrtc_pkg::crc16_byte(crc_q, data_byte_i);

  assign push_entry_o.data_byte  = data_byte_i;
  assign push_entry_o.frame_last = frame_last_i;
  assign push_entry_o.crc        = crc_next;

  always_comb begin
    crc_d = crc_q;
    if (push_o) begin
      // re-arm after the last byte of a frame
      crc_d = frame_last_i ? mrtc_pkg::CrcInit : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mrtc_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

// ----- rtl/mrtc_fifo.sv -----
// ----------------------------------------------------------------------------
// mrtc_fifo
// short register queue between the front and the back end
// ----------------------------------------------------------------------------
module mrtc_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  mrtc_pkg::mrtc_entry_t        push_entry_i,
  input  logic                         pop_i,
  output mrtc_pkg::mrtc_entry_t        head_o,
  output mrtc_pkg::mrtc_fifo_status_t  status_o
);

  localparam logic [mrtc_pkg::FifoPtrW-1:0] LastPtr =
    mrtc_pkg::FifoPtrW'(mrtc_pkg::FifoDepth - 1);
  localparam logic [mrtc_pkg::FifoCntW-1:0] FullCnt =
    mrtc_pkg::FifoCntW'(mrtc_pkg::FifoDepth);

  mrtc_pkg::mrtc_entry_t mem_q [mrtc_pkg::FifoDepth];

  logic [mrtc_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [mrtc_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [mrtc_pkg::FifoCntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/mrtc_back.sv -----
// ----------------------------------------------------------------------------
// mrtc_back
// walks each queued byte through its output phases (payload, and after a
// frame's last byte crc low, then crc high) into a registered output stage
// ----------------------------------------------------------------------------
module mrtc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrtc_pkg::mrtc_entry_t        head_i,
  input  mrtc_pkg::mrtc_fifo_status_t  fifo_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mrtc_pkg::ByteW-1:0]   tx_byte_o,
  output logic                         is_crc_o,
  output logic                         run_last_o,
  output logic                         frame_done_o
);

  logic [mrtc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic                        valid_q, valid_d;
  logic [mrtc_pkg::ByteW-1:0]  byte_q, byte_d;
  logic                        is_crc_q, is_crc_d;
  logic                        run_last_q, run_last_d;
  logic                        done_q, done_d;
  logic                        load;

  // output register free to take a new result, and a queued byte present
  assign load = (~valid_q | out_ready_i) & ~fifo_status_i.empty;

  always_comb begin
    phase_d    = phase_q;
    byte_d     = byte_q;
    is_crc_d   = is_crc_q;
    run_last_d = run_last_q;
    done_d     = done_q;
    pop_o      = 1'b0;
    valid_d    = valid_q & ~out_ready_i;
    if (load) begin
      valid_d = 1'b1;
      unique case (phase_q)
        mrtc_pkg::PhData: begin
          byte_d     = head_i.data_byte;
          is_crc_d   = 1'b0;
          run_last_d = ~head_i.frame_last;
          done_d     = 1'b0;
          pop_o      = ~head_i.frame_last;
          phase_d    = head_i.frame_last ? mrtc_pkg::PhCrcLo : mrtc_pkg::PhData;
        end
        mrtc_pkg::PhCrcLo: begin
          byte_d     = head_i.crc[mrtc_pkg::ByteW-1:0];
          is_crc_d   = 1'b1;
          run_last_d = 1'b0;
          done_d     = 1'b0;
          phase_d    = mrtc_pkg::PhCrcHi;
        end
        mrtc_pkg::PhCrcHi: begin
          byte_d     = head_i.crc[mrtc_pkg::CrcW-1:mrtc_pkg::ByteW];
          is_crc_d   = 1'b1;
          run_last_d = 1'b1;
          done_d     = 1'b1;
          pop_o      = 1'b1;
          phase_d    = mrtc_pkg::PhData;
        end
        default: begin
          valid_d = valid_q & ~out_ready_i;
          phase_d = mrtc_pkg::PhData;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mrtc_pkg::PhData;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    is_crc_q   <= is_crc_d;
    run_last_q <= run_last_d;
    done_q     <= done_d;
  end

  assign out_valid_o  = valid_q;
  assign tx_byte_o    = byte_q;
  assign is_crc_o     = is_crc_q;
  assign run_last_o   = run_last_q;
  assign frame_done_o = done_q;

endmodule

// ----- rtl/modbus_rtu_tx_crc_append.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_tx_crc_append
// modbus rtu transmit framer: passes payload bytes through and appends the
// crc-16 (low byte, then high byte) after the last byte of each frame
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake               payload
//   -------  ---  ----------------------  ------------------------------------
//   in       in   in_valid_i/in_ready_o   data_byte_i, frame_last_i
//   out      out  out_valid_o/out_ready_i tx_byte_o, is_crc_o, run_last_o,
//                                         frame_done_o
//
// one input byte is taken per cycle while the two-entry queue has room; the
// crc update for a byte is done in the accept cycle
// the back end sends one result per cycle unless the queue is empty or the
// output stalls: one per middle byte, three per last byte, so a frame of n
// bytes yields n + 2 results; the first result is written to the queue at the
// accept edge and then loaded from the queue head into the output register
// reset clears the crc to 0xffff, empties the queue, idles the output stage
// a stalled output fills the queue, then drops in_ready_o
//
module modbus_rtu_tx_crc_append (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input transfer
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mrtc_pkg::ByteW-1:0] data_byte_i,
  input  logic                       frame_last_i,
  // output transfer
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mrtc_pkg::ByteW-1:0] tx_byte_o,
  output logic                       is_crc_o,
  output logic                       run_last_o,
  output logic                       frame_done_o
);

  mrtc_pkg::mrtc_fifo_status_t fifo_status;
  mrtc_pkg::mrtc_entry_t       push_entry;
  mrtc_pkg::mrtc_entry_t       head;
  logic                        push;
  logic                        pop;

  // front: running crc, each byte queued with the crc that covers it
  mrtc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .frame_last_i  (frame_last_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  // decouples input acceptance from the multi-result output sequence
  mrtc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (fifo_status)
  );

  // back: payload byte, then crc low and high on a frame's last byte
  mrtc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_byte_o     (tx_byte_o),
    .is_crc_o      (is_crc_o),
    .run_last_o    (run_last_o),
    .frame_done_o  (frame_done_o)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the modbus rtu transmit crc append block: each payload byte must pass
// through unchanged, and the last byte of a frame must be followed by the
// crc-16 low byte, then the crc-16 high byte with the frame-done mark set.
// a short table of directed frames runs first, then random frames, with
// random idle bursts on both sides and a closing stretch at full rate
// ----------------------------------------------------------------------------
module tb_top;
  import mrtc_pkg::*;

  localparam int unsigned DirRows     = 19;
  localparam int unsigned NumItems    = 260;   // whole run, in bytes, at least
  localparam int unsigned QuietTail   = 60;    // closing bytes with no idling
  localparam int unsigned IdleLimit   = 2000;  // cycles with no transfer at all
  localparam int unsigned DrainCycles = 8;     // cycles to wait for stray bytes after the drain

  // one result on the serial side
  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             is_crc;
    logic             run_last;
    logic             frame_done;
  } tx_res_t;

  // one row of the directed table; crc_known rows carry a crc typed in by hand
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_last;
    logic             crc_known;
    logic [CrcW-1:0]  crc_val;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i;
  logic             frame_last_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ByteW-1:0] tx_byte_o;
  logic             is_crc_o;
  logic             run_last_o;
  logic             frame_done_o;

  // directed frames
  dir_row_t dir_tab [DirRows] = '{
    // single zero byte right after reset: crc 0x40bf
    '{8'h00, 1'b1, 1'b1, 16'h40BF},
    // single all-ones byte: crc 0x00ff
    '{8'hFF, 1'b1, 1'b1, 16'h00FF},
    // the usual check string "123456789": crc 0x4b37
    '{8'h31, 1'b0, 1'b1, 16'h4B37},
    '{8'h32, 1'b0, 1'b1, 16'h4B37},
    '{8'h33, 1'b0, 1'b1, 16'h4B37},
    '{8'h34, 1'b0, 1'b1, 16'h4B37},
    '{8'h35, 1'b0, 1'b1, 16'h4B37},
    '{8'h36, 1'b0, 1'b1, 16'h4B37},
    '{8'h37, 1'b0, 1'b1, 16'h4B37},
    '{8'h38, 1'b0, 1'b1, 16'h4B37},
    '{8'h39, 1'b1, 1'b1, 16'h4B37},
    // alternating bit patterns, single-bit bytes and their inverses, all-zero and all-ones, crc from the predictor
    '{8'hAA, 1'b0, 1'b0, 16'h0000},
    '{8'h55, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b1, 1'b0, 16'h0000},
    '{8'h01, 1'b1, 1'b0, 16'h0000},
    '{8'h7F, 1'b0, 1'b0, 16'h0000},
    '{8'hFE, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 1'b1, 1'b0, 16'h0000}
  };

  logic [CrcW-1:0] frame_crc = CrcInit;  // running crc of the frame in flight
  tx_res_t         tx_expect_q [$];      // serial bytes still to come
  int unsigned     fail_cnt   = 0;
  int unsigned     idle_cnt   = 0;
  int unsigned     sent_cnt   = 0;
  int unsigned     stall_left = 0;
  bit              gaps_on    = 1'b0;
  bit              stalls_on  = 1'b0;

  modbus_rtu_tx_crc_append uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .frame_last_i(frame_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .is_crc_o    (is_crc_o),
    .run_last_o  (run_last_o),
    .frame_done_o(frame_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // crc-16 over one byte, one data bit at a time, lsb first
  function automatic logic [CrcW-1:0] crc_after_byte(input logic [CrcW-1:0]  crc,
                                                     input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // queue the serial bytes that one accepted payload byte must produce
  task automatic expect_tx_bytes(input logic [ByteW-1:0] b, input logic last,
                                 input logic known, input logic [CrcW-1:0] known_crc);
    logic [CrcW-1:0] crc;
    crc = crc_after_byte(frame_crc, b);
    if (!last) begin
      frame_crc = crc;
      tx_expect_q.push_back('{b, 1'b0, 1'b1, 1'b0});
    end else begin
      if (known) begin
        crc = known_crc;
      end
      tx_expect_q.push_back('{b, 1'b0, 1'b0, 1'b0});
      tx_expect_q.push_back('{crc[7:0], 1'b1, 1'b0, 1'b0});
      tx_expect_q.push_back('{crc[15:8], 1'b1, 1'b1, 1'b1});
      // crc re-arms for the next frame
      frame_crc = CrcInit;
    end
  endtask

  // offer one payload byte, maybe after an idle burst, and wait for its transfer
  // entered and left at a rising edge; in_valid_i gets one assignment per edge
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last,
                           input logic known, input logic [CrcW-1:0] known_crc);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    frame_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    expect_tx_bytes(b, last, known, known_crc);
    sent_cnt++;
  endtask

  // serial side back-pressure: random stall bursts while enabled
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare every serial transfer with the oldest expected byte
  always @(posedge clk_i) begin : tx_check
    tx_res_t want;
    tx_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{tx_byte_o, is_crc_o, run_last_o, frame_done_o};
      if (tx_expect_q.size() == 0) begin
        if (fail_cnt < 10) begin
          $display("%0t: unexpected transfer: byte %02h is_crc %0b run_last %0b frame_done %0b",
                   $time, got.tx_byte, got.is_crc, got.run_last, got.frame_done);
        end
        fail_cnt++;
      end else begin
        want = tx_expect_q.pop_front();
        if (got !== want) begin
          if (fail_cnt < 10) begin
            $display("%0t: mismatch: expected byte %02h is_crc %0b run_last %0b frame_done %0b",
                     $time, want.tx_byte, want.is_crc, want.run_last, want.frame_done);
            $display("%0t:           got      byte %02h is_crc %0b run_last %0b frame_done %0b",
                     $time, got.tx_byte, got.is_crc, got.run_last, got.frame_done);
          end
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int unsigned      len;
    logic [ByteW-1:0] b;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    frame_last_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, with idling on both sides
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data_byte, dir_tab[i].frame_last,
                dir_tab[i].crc_known, dir_tab[i].crc_val);
    end

    // random frames, mostly short, now and then long; always whole frames
    while (sent_cnt < NumItems) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      if (sent_cnt >= NumItems - QuietTail) begin
        // closing stretch at full rate
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = 1'($urandom_range(0, 1));
        stalls_on = 1'($urandom_range(0, 1));
      end
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = '1;
          default: b = ByteW'($urandom_range(0, 255));
        endcase
        send_byte(b, k == len - 1, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // drain, then give stray bytes a chance to show up
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0 && tx_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mrtc_pkg.sv
rtl/mrtc_front.sv
rtl/mrtc_fifo.sv
rtl/mrtc_back.sv
rtl/modbus_rtu_tx_crc_append.sv
test/tb_top.sv
